FILE: sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: item
// layouts, header entry layout, opcodes, status codes and register map.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // Default geometry of the arena.
   localparam int ARENA_BYTES_DEF  = 4096;
   localparam int HEADER_BYTES_DEF = 8;
   localparam int LOCK_BYTES_DEF   = 32;

   // Field widths.
   localparam int FIELD_W = 13;
   // Internal offset width: room for an offset plus a size and two headers.
   localparam int OFF_W   = 14;

   localparam logic [FIELD_W-1:0] HEAP_LEN_RESET = 13'd4096;

   // Opcodes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Status codes.
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_NO_FIT = 1'b1;

   // Register map: paddr[2] selects the register.
   localparam int   CSR_ADDR_W   = 3;
   localparam logic REG_HEAP_LEN = 1'b0;

   typedef struct packed {
      logic               opcode;
      logic [FIELD_W-1:0] request_bytes;
      logic [FIELD_W-1:0] block_offset;
   } req_item_type;

   typedef struct packed {
      logic [FIELD_W-1:0] result_offset;
      logic               status;
   } rsp_item_type;

   // One header: free bit and byte offset of the next header.
   typedef struct packed {
      logic               free;
      logic [FIELD_W-1:0] next;
   } hdr_entry_type;

endpackage

FILE: sv/ffba_hdr_ram.sv
// ----------------------------------------------------------------------------
// ffba_hdr_ram
// Header store: one entry per 8-byte granule, one write port and one read
// port, read data registered.
// ----------------------------------------------------------------------------
module ffba_hdr_ram #(
   parameter  int DEPTH = ffba_pkg::ARENA_BYTES_DEF / 8,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  ffba_pkg::hdr_entry_type wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output ffba_pkg::hdr_entry_type rd_data
);
   import ffba_pkg::*;

   hdr_entry_type hdr_mem [DEPTH];
   hdr_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hdr_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit heap allocator with coalescing. Headers live in a granule
// indexed store; allocate and free requests walk the header list from the
// first header, one header per cycle.
// ----------------------------------------------------------------------------
//
//   channel  | dir | contents
//   ---------+-----+-----------------------------------------------------
//   req_*    | in  | opcode, request_bytes, block_offset
//   rsp_*    | out | result_offset, status (one per request)
//   csr_*    | in  | APB write/read of heap_len at byte address 0
//
// One item at a time: a new request is taken only in the idle state, and the
// header walk goes through the single read port of the header store.
// After reset and after every heap_len write, the format state writes the first
// header; entries off the header list are never read, so no other clearing.
// A stalled result waits in its output register while the next item walks.
module first_fit_block_allocator_unit #(
   parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
   parameter int LOCK_BYTES   = ffba_pkg::LOCK_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ffba_pkg::req_item_type          req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ffba_pkg::rsp_item_type          rsp_item,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import ffba_pkg::*;

   localparam int GRANULES = ARENA_BYTES / 8;
   localparam int AW       = $clog2(GRANULES);
   localparam int LEN_MIN  = (LOCK_BYTES + HEADER_BYTES + 7) / 8 * 8;
   localparam logic [OFF_W-1:0] HDR  = OFF_W'(HEADER_BYTES);
   localparam logic [OFF_W-1:0] LOCK = OFF_W'(LOCK_BYTES);

   typedef enum logic [2:0] {
      ST_FORMAT,
      ST_IDLE,
      ST_START,
      ST_WALK,
      ST_SPLIT,
      ST_MERGE,
      ST_RESP
   } state_type;

   function automatic logic [FIELD_W-1:0] clamp_len(input logic [FIELD_W-1:0] v);
      logic [31:0] x;
      x = 32'(v);
      if (x > 32'(ARENA_BYTES)) begin
         x = 32'(ARENA_BYTES);
      end
      x = x & ~32'd7;
      if (x < 32'(LEN_MIN)) begin
         x = 32'(LEN_MIN);
      end
      return x[FIELD_W-1:0];
   endfunction

   function automatic logic [AW-1:0] slot(input logic [OFF_W-1:0] off);
      return AW'(off >> 3);
   endfunction

   state_type          state_ff, state_in;
   logic [FIELD_W-1:0] heap_len_ff, heap_len_in;
   logic               op_ff, op_in;
   logic [OFF_W-1:0]   sz_h_ff, sz_h_in;
   logic [OFF_W-1:0]   sz_2h_ff, sz_2h_in;
   logic [OFF_W-1:0]   target_ff, target_in;
   logic               bad_ff, bad_in;
   logic [OFF_W-1:0]   cur_ff, cur_in;
   logic [OFF_W-1:0]   prev_ff, prev_in;
   logic               prev_free_ff, prev_free_in;
   logic [FIELD_W-1:0] tnext_ff, tnext_in;
   logic               tn_live_ff, tn_live_in;
   logic [OFF_W-1:0]   nh_ff, nh_in;
   logic [FIELD_W-1:0] res_offset_ff, res_offset_in;
   logic               res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;

   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   hdr_entry_type      rd_data, wr_data;

   logic               cfg_wr;
   logic [OFF_W-1:0]   heap_ext;
   logic [OFF_W-1:0]   walk_next;
   logic [OFF_W-1:0]   walk_diff;
   logic [OFF_W-1:0]   req_sz;
   logic [OFF_W-1:0]   req_boff;
   logic               merge_next_free;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_HEAP_LEN);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HEAP_LEN) ? 32'(heap_len_ff) : 32'd0;

   assign heap_ext  = {1'b0, heap_len_ff};
   assign walk_next = {1'b0, rd_data.next};
   assign walk_diff = walk_next - cur_ff;
   assign req_sz    = ({1'b0, req_item.request_bytes} + OFF_W'(7)) & ~OFF_W'(7);
   assign req_boff  = {1'b0, req_item.block_offset};
   assign merge_next_free = tn_live_ff && rd_data.free;

   ffba_hdr_ram #(
      .DEPTH (GRANULES)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      heap_len_in   = heap_len_ff;
      op_in         = op_ff;
      sz_h_in       = sz_h_ff;
      sz_2h_in      = sz_2h_ff;
      target_in     = target_ff;
      bad_in        = bad_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_free_in  = prev_free_ff;
      tnext_in      = tnext_ff;
      tn_live_in    = tn_live_ff;
      nh_in         = nh_ff;
      res_offset_in = res_offset_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = slot(walk_next);
      wr_en         = 1'b0;
      wr_addr       = slot(cur_ff);
      wr_data       = '{free: 1'b0, next: rd_data.next};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_FORMAT: begin
            wr_en    = 1'b1;
            wr_addr  = slot(LOCK);
            wr_data  = '{free: 1'b1, next: heap_len_ff};
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_item.opcode;
               sz_h_in       = req_sz + HDR;
               sz_2h_in      = req_sz + HDR + HDR;
               target_in     = req_boff - HDR;
               bad_in        = req_boff < HDR;
               cur_in        = LOCK;
               prev_in       = LOCK;
               prev_free_in  = 1'b0;
               res_offset_in = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_START;
            end
         end
         ST_START: begin
            rd_addr = slot(cur_ff);
            if (op_ff == OP_ALLOC) begin
               if (cur_ff < heap_ext) begin
                  rd_en    = 1'b1;
                  state_in = ST_WALK;
               end else begin
                  res_offset_in = heap_len_ff;
                  res_status_in = STATUS_NO_FIT;
                  state_in      = ST_RESP;
               end
            end else if (!bad_ff && cur_ff < heap_ext && cur_ff <= target_ff) begin
               rd_en    = 1'b1;
               state_in = ST_WALK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WALK: begin
            if (op_ff == OP_ALLOC) begin
               if (walk_next <= cur_ff) begin
                  res_offset_in = heap_len_ff;
                  res_status_in = STATUS_NO_FIT;
                  state_in      = ST_RESP;
               end else if (rd_data.free && walk_diff == sz_h_ff) begin
                  // Exact fit: mark the block taken.
                  wr_en         = 1'b1;
                  wr_data       = '{free: 1'b0, next: rd_data.next};
                  res_offset_in = FIELD_W'(cur_ff + HDR);
                  state_in      = ST_RESP;
               end else if (rd_data.free && walk_diff >= sz_2h_ff) begin
                  // Split: the new free header goes in now, the shortened
                  // header of this block in the next cycle.
                  wr_en         = 1'b1;
                  wr_addr       = slot(cur_ff + sz_h_ff);
                  wr_data       = '{free: 1'b1, next: rd_data.next};
                  nh_in         = cur_ff + sz_h_ff;
                  res_offset_in = FIELD_W'(cur_ff + HDR);
                  state_in      = ST_SPLIT;
               end else begin
                  cur_in = walk_next;
                  if (walk_next < heap_ext) begin
                     rd_en = 1'b1;
                  end else begin
                     res_offset_in = heap_len_ff;
                     res_status_in = STATUS_NO_FIT;
                     state_in      = ST_RESP;
                  end
               end
            end else begin
               if (cur_ff == target_ff) begin
                  // Found the block; fetch its successor for the merge.
                  tnext_in   = rd_data.next;
                  tn_live_in = walk_next < heap_ext;
                  rd_en      = walk_next < heap_ext;
                  state_in   = ST_MERGE;
               end else if (walk_next <= cur_ff) begin
                  state_in = ST_RESP;
               end else begin
                  prev_in      = cur_ff;
                  prev_free_in = rd_data.free;
                  cur_in       = walk_next;
                  if (walk_next < heap_ext && walk_next <= target_ff) begin
                     rd_en = 1'b1;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
            end
         end
         ST_SPLIT: begin
            wr_en    = 1'b1;
            wr_data  = '{free: 1'b0, next: nh_ff[FIELD_W-1:0]};
            state_in = ST_RESP;
         end
         ST_MERGE: begin
            wr_en = 1'b1;
            if (prev_free_ff) begin
               wr_addr = slot(prev_ff);
               wr_data = '{free: 1'b1,
                           next: merge_next_free ? rd_data.next : tnext_ff};
            end else begin
               wr_data = '{free: 1'b1,
                           next: merge_next_free ? rd_data.next : tnext_ff};
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_offset: res_offset_ff, status: res_status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_FORMAT;
         end
      endcase

      // A heap_len write reformats the heap.
      if (cfg_wr) begin
         heap_len_in = clamp_len(csr_pwdata[FIELD_W-1:0]);
         state_in    = ST_FORMAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FORMAT;
         heap_len_ff  <= clamp_len(HEAP_LEN_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_len_ff  <= heap_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      sz_h_ff       <= sz_h_in;
      sz_2h_ff      <= sz_2h_in;
      target_ff     <= target_in;
      bad_ff        <= bad_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_free_ff  <= prev_free_in;
      tnext_ff      <= tnext_in;
      tn_live_ff    <= tn_live_in;
      nh_ff         <= nh_in;
      res_offset_ff <= res_offset_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The walk only ever reads headers inside the arena.
   a_walk_in_arena: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> cur_ff < heap_ext)
      else $error("header walk beyond heap length");

   // The store is never read and written at the same entry in one cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> rd_addr != wr_addr)
      else $error("header store read and write collide");

   // A new split header lies after the header being split and inside the heap.
   a_split_inside: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SPLIT |-> nh_ff > cur_ff && nh_ff < heap_ext)
      else $error("split header outside its block");

   // Every heap_len write is followed by a reformat.
   a_cfg_formats: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> state_ff == ST_FORMAT)
      else $error("heap_len write without reformat");

endmodule
